@@ design/shm_pkg.sv @@
// ----------------------------------------------------------------------------
// shm_pkg
// Shared types and constants of the SHA-256 message hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package shm_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } shm_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } shm_out_t;

  localparam int BLK_BITS = 512;

  typedef struct packed {
    logic                final_blk;
    logic [BLK_BITS-1:0] data;
  } shm_blk_t;

  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam logic [31:0] SHM_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] SHM_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef enum logic [3:0] {
    FS_ACCEPT = 4'b0001,
    FS_FLUSH  = 4'b0010,
    FS_PAD    = 4'b0100,
    FS_PAD2   = 4'b1000
  } shm_fstate_t;

  typedef enum logic [2:0] {
    CS_IDLE = 3'b001,
    CS_RUN  = 3'b010,
    CS_FIN  = 3'b100
  } shm_cstate_t;

endpackage

`default_nettype wire

@@ design/sha256_message_hasher.sv @@
// ----------------------------------------------------------------------------
// sha256_message_hasher
// Streaming SHA-256 over a byte message; eight digest words per message.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle in bursts while in_full is low.
// Each block passes the round engine in steps (load, 64 rounds, update);
// intake stalls after each 64th byte and after end of message while the blocks are pushed.
// The first digest word follows end of message once the final block is hashed, plus queue wait.
// Reset: synchronous active-low; clears queues, counters, chaining words to IV.
`default_nettype none

module sha256_message_hasher import shm_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_push,
  output logic          in_full,
  input  wire shm_in_t  in_item,
  output logic          out_empty,
  input  wire logic     out_pop,
  output shm_out_t      out_item
);

  logic     f_push, f_ready, q_valid, q_pop;
  shm_blk_t f_blk, q_blk;

  shm_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_item,
    .blk_push (f_push), .blk_out (f_blk), .blk_ready (f_ready)
  );

  shm_fifo u_fifo (
    .clk, .rst_n,
    .wr_en (f_push), .wr_data (f_blk), .wr_ready (f_ready),
    .rd_en (q_pop), .rd_data (q_blk), .rd_valid (q_valid)
  );

  shm_core u_core (
    .clk, .rst_n,
    .blk_valid (q_valid), .blk_in (q_blk), .blk_pop (q_pop),
    .out_empty, .out_pop, .out_item
  );

endmodule

`default_nettype wire

@@ design/shm_front.sv @@
// ----------------------------------------------------------------------------
// shm_front
// Gathers message bytes into 64-byte blocks, appends padding and length.
// ----------------------------------------------------------------------------
`default_nettype none

module shm_front import shm_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_push,
  output logic          in_full,
  input  wire shm_in_t  in_item,
  output logic          blk_push,
  output shm_blk_t      blk_out,
  input  wire logic     blk_ready
);

  shm_fstate_t          state_r, state_nxt;
  logic [BLK_BITS-1:0]  buf_r, buf_nxt;
  logic [6:0]           fill_r, fill_nxt, fill_inc;
  logic [60:0]          cnt_r, cnt_nxt;
  logic                 eom_r, eom_nxt;
  logic [63:0]          bit_len;
  logic [BLK_BITS-1:0]  pad_data;
  logic                 pad_final;
  logic                 is_pad2;

  assign in_full  = (state_r != FS_ACCEPT);
  assign bit_len  = {cnt_r, 3'b000};
  assign is_pad2  = (state_r == FS_PAD2);
  assign pad_final = is_pad2 || (fill_r <= 7'd55);
  assign fill_inc = fill_r + {6'd0, in_item.byte_present};

  always_comb begin
    for (int p = 0; p < 64; p++) begin
      if (pad_final && p >= 56) begin
        pad_data[BLK_BITS-1-8*p -: 8] = bit_len[63-8*(p-56) -: 8];
      end else if (!is_pad2 && p < fill_r) begin
        pad_data[BLK_BITS-1-8*p -: 8] = buf_r[BLK_BITS-1-8*p -: 8];
      end else if (!is_pad2 && p == fill_r) begin
        pad_data[BLK_BITS-1-8*p -: 8] = PAD_MARK;
      end else begin
        pad_data[BLK_BITS-1-8*p -: 8] = 8'd0;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    buf_nxt   = buf_r;
    fill_nxt  = fill_r;
    cnt_nxt   = cnt_r;
    eom_nxt   = eom_r;
    blk_push  = 1'b0;
    blk_out.final_blk = 1'b0;
    blk_out.data      = buf_r;
    unique case (state_r)
      FS_ACCEPT: begin
        if (in_push) begin
          if (in_item.byte_present) begin
            for (int p = 0; p < 64; p++) begin
              if (p == fill_r) begin
                buf_nxt[BLK_BITS-1-8*p -: 8] = in_item.data_byte;
              end
            end
            cnt_nxt = cnt_r + 61'd1;
          end
          fill_nxt = fill_inc;
          eom_nxt  = in_item.end_of_message;
          if (fill_inc == 7'd64) begin
            state_nxt = FS_FLUSH;
          end else if (in_item.end_of_message) begin
            state_nxt = FS_PAD;
          end
        end
      end
      FS_FLUSH: begin
        blk_push = 1'b1;
        if (blk_ready) begin
          fill_nxt  = 7'd0;
          state_nxt = eom_r ? FS_PAD : FS_ACCEPT;
        end
      end
      FS_PAD, FS_PAD2: begin
        blk_push          = 1'b1;
        blk_out.final_blk = pad_final;
        blk_out.data      = pad_data;
        if (blk_ready) begin
          if (pad_final) begin
            fill_nxt  = 7'd0;
            cnt_nxt   = 61'd0;
            state_nxt = FS_ACCEPT;
          end else begin
            state_nxt = FS_PAD2;
          end
        end
      end
      default: state_nxt = FS_ACCEPT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_ACCEPT;
      fill_r  <= 7'd0;
      cnt_r   <= 61'd0;
      eom_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      cnt_r   <= cnt_nxt;
      eom_r   <= eom_nxt;
    end
    buf_r <= buf_nxt;
  end

endmodule

`default_nettype wire

@@ design/shm_fifo.sv @@
// ----------------------------------------------------------------------------
// shm_fifo
// Two-entry block queue between the byte gatherer and the compression core.
// ----------------------------------------------------------------------------
`default_nettype none

module shm_fifo import shm_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     wr_en,
  input  wire shm_blk_t wr_data,
  output logic          wr_ready,
  input  wire logic     rd_en,
  output shm_blk_t      rd_data,
  output logic          rd_valid
);

  shm_blk_t   mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_wr, do_rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign do_wr    = wr_en && wr_ready;
  assign do_rd    = rd_en && rd_valid;

  always_comb begin
    wp_nxt  = do_wr ? ~wp_r : wp_r;
    rp_nxt  = do_rd ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, do_wr} - {1'b0, do_rd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

@@ design/shm_core.sv @@
// ----------------------------------------------------------------------------
// shm_core
// One SHA-256 round per cycle; holds the chaining words and the digest.
// ----------------------------------------------------------------------------
`default_nettype none

module shm_core import shm_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     blk_valid,
  input  wire shm_blk_t blk_in,
  output logic          blk_pop,
  output logic          out_empty,
  input  wire logic     out_pop,
  output shm_out_t      out_item
);

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  shm_cstate_t  state_r, state_nxt;
  logic [31:0]  w_r [16];
  logic [31:0]  v_r [8];
  logic [31:0]  h_r [8];
  logic [31:0]  dig_r [8];
  logic [5:0]   rnd_r;
  logic         fin_r;
  logic         dig_valid_r;
  logic [2:0]   oidx_r;
  logic [31:0]  w_new, t1, t2, e, a;
  logic         dig_load;

  assign e = v_r[4];
  assign a = v_r[0];
  assign w_new = (rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10))
               + w_r[9] + (rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3))
               + w_r[0];
  assign t1 = v_r[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
            + ((e & v_r[5]) ^ (~e & v_r[6])) + SHM_K[rnd_r] + w_r[0];
  assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
            + ((a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]));

  assign blk_pop   = (state_r == CS_IDLE) && blk_valid;
  assign dig_load  = (state_r == CS_FIN) && fin_r && !dig_valid_r;
  assign out_empty = !dig_valid_r;
  assign out_item.digest_word = dig_r[oidx_r];
  assign out_item.word_index  = oidx_r;
  assign out_item.last_word   = (oidx_r == 3'd7);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CS_IDLE: if (blk_valid) state_nxt = CS_RUN;
      CS_RUN:  if (rnd_r == 6'd63) state_nxt = CS_FIN;
      CS_FIN:  if (!fin_r || !dig_valid_r) state_nxt = CS_IDLE;
      default: state_nxt = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= CS_IDLE;
      dig_valid_r <= 1'b0;
      oidx_r      <= 3'd0;
      for (int i = 0; i < 8; i++) h_r[i] <= SHM_IV[i];
    end else begin
      state_r <= state_nxt;
      if (state_r == CS_FIN && (!fin_r || !dig_valid_r)) begin
        for (int i = 0; i < 8; i++) h_r[i] <= fin_r ? SHM_IV[i] : h_r[i] + v_r[i];
      end
      if (dig_load) begin
        dig_valid_r <= 1'b1;
        oidx_r      <= 3'd0;
      end else if (out_pop && dig_valid_r) begin
        oidx_r <= oidx_r + 3'd1;
        if (oidx_r == 3'd7) dig_valid_r <= 1'b0;
      end
    end
    if (dig_load) begin
      for (int i = 0; i < 8; i++) dig_r[i] <= h_r[i] + v_r[i];
    end
    if (blk_pop) begin
      for (int i = 0; i < 16; i++) w_r[i] <= blk_in.data[BLK_BITS-1-32*i -: 32];
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
      rnd_r <= 6'd0;
      fin_r <= blk_in.final_blk;
    end else if (state_r == CS_RUN) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= w_new;
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
      rnd_r  <= rnd_r + 6'd1;
    end
  end

endmodule

`default_nettype wire

@@ design/shm_checker.sv @@
// ----------------------------------------------------------------------------
// shm_checker
// Port-level checks of the hasher's digest output sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module shm_checker import shm_pkg::*; (
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     out_empty,
  input wire logic     out_pop,
  input wire shm_out_t out_item
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("output not empty after reset");

  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_item.last_word == (out_item.word_index == 3'd7)))
    else $error("last_word disagrees with word_index");

  a_next_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pop && !out_empty && !out_item.last_word) |=>
      (!out_empty && out_item.word_index == $past(out_item.word_index) + 3'd1))
    else $error("digest words not contiguous");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_item)))
    else $error("waiting transaction changed");

endmodule

bind sha256_message_hasher shm_checker u_shm_checker (
  .clk, .rst_n, .out_empty, .out_pop, .out_item
);

`default_nettype wire

@@ tb/sha256_checker.sv @@
// ----------------------------------------------------------------------------
// sha256_checker
// Watches both channels of the SHA-256 message hasher, predicts the eight
// digest words of every finished message and compares them in order.
// ----------------------------------------------------------------------------
module sha256_checker import shm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  input  logic     in_full,
  input  shm_in_t  in_item,
  input  logic     out_empty,
  input  logic     out_pop,
  input  shm_out_t out_item,
  output int       fail_count,
  output int       pending_words
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0] chain [8];
  logic [7:0]  blk_bytes [64];
  int          blk_fill;
  logic [60:0] byte_total;
  shm_out_t    digest_q [$];

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic hash_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, s0, s1;
    for (int i = 0; i < 16; i++)
      w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHM_K[r] + w[r];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] += v[i];
  endtask

  task automatic absorb_item(shm_in_t it);
    logic [63:0] bit_len;
    shm_out_t    e;
    if (it.byte_present) begin
      blk_bytes[blk_fill] = it.data_byte;
      blk_fill++;
      byte_total++;
      if (blk_fill == 64) begin
        hash_block();
        blk_fill = 0;
      end
    end
    if (it.end_of_message) begin
      blk_bytes[blk_fill] = PAD_MARK;
      blk_fill++;
      if (blk_fill > 56) begin
        while (blk_fill < 64) blk_bytes[blk_fill++] = 8'h00;
        hash_block();
        blk_fill = 0;
      end
      while (blk_fill < 56) blk_bytes[blk_fill++] = 8'h00;
      bit_len = {byte_total, 3'b000};
      for (int i = 0; i < 8; i++) blk_bytes[56+i] = bit_len[63-8*i -: 8];
      hash_block();
      for (int i = 0; i < 8; i++) begin
        e.digest_word = chain[i];
        e.word_index  = i[2:0];
        e.last_word   = (i == 7);
        digest_q = {digest_q, e};
      end
      for (int i = 0; i < 8; i++) chain[i] = SHM_IV[i];
      blk_fill   = 0;
      byte_total = '0;
    end
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    for (int i = 0; i < 8; i++) chain[i] = SHM_IV[i];
    blk_fill   = 0;
    byte_total = '0;
  end

  always @(posedge clk) begin
    shm_out_t e;
    if (rst_n) begin
      if (in_push && !in_full) absorb_item(in_item);
      if (out_pop && !out_empty) begin
        if (digest_q.size() == 0) begin
          report("unexpected word", out_item.digest_word, 32'h0);
        end else begin
          e = digest_q.pop_front();
          if (out_item.digest_word !== e.digest_word)
            report("digest_word", out_item.digest_word, e.digest_word);
          if (out_item.word_index !== e.word_index)
            report("word_index", 32'(out_item.word_index), 32'(e.word_index));
          if (out_item.last_word !== e.last_word)
            report("last_word", 32'(out_item.last_word), 32'(e.last_word));
        end
      end
    end
    pending_words <= digest_q.size();
  end

  initial pending_words = 0;
endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives byte messages of many lengths into the SHA-256 message hasher with
// random gaps and stalls; the checker predicts and compares every digest.
// ----------------------------------------------------------------------------
module testbench;
  import shm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 5000;

  logic     clk = 0;
  logic     rst_n = 0;
  logic     in_push = 0;
  logic     in_full;
  shm_in_t  in_item = '0;
  logic     out_empty;
  logic     out_pop = 0;
  shm_out_t out_item;
  int       fail_count;
  int       pending_words;
  int       idle_cycles = 0;
  bit       hold_off = 0;
  bit       stim_done = 0;

  sha256_message_hasher DUT (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full),
    .in_item(in_item), .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item)
  );

  sha256_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full),
    .in_item(in_item), .out_empty(out_empty), .out_pop(out_pop),
    .out_item(out_item), .fail_count(fail_count), .pending_words(pending_words)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic send(logic [7:0] b, bit present, bit eom);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_push <= 0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1;
    in_item <= '{data_byte: b, byte_present: present, end_of_message: eom};
    do @(posedge clk); while (in_full);
  endtask

  task automatic send_message(int len, bit empty_tail);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0)
        send(8'($urandom_range(0, 255)), 0, 0);
      send(8'($urandom_range(0, 255)), 1, (i == len - 1) && !empty_tail);
    end
    if (empty_tail || len == 0) send(8'($urandom_range(0, 255)), 0, 1);
  endtask

  initial begin
    int len;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send(8'h00, 0, 1);
    send(8'hff, 0, 1);
    send(8'h00, 1, 0);
    send(8'hff, 1, 0);
    send(8'h55, 0, 0);
    send(8'haa, 1, 1);
    send_message(3, 0);
    send_message(1, 1);
    send_message(56, 0);
    send_message(64, 0);
    hold_off = 1;
    send_message(20, 0);
    send_message(6, 0);
    send_message(6, 0);
    hold_off = 0;
    for (int m = 0; m < 6; m++) begin
      len = $urandom_range(0, 8);
      send_message(len, 1'($urandom_range(0, 1)));
    end
    in_push <= 0;
    stim_done = 1;
  end

  initial begin
    int gap;
    wait (rst_n);
    forever begin
      gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 8);
      if (hold_off) begin
        out_pop <= 0;
        repeat (400) @(posedge clk);
        wait (!hold_off);
      end else if (gap > 0) begin
        out_pop <= 0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1;
      do @(posedge clk); while (out_empty);
    end
  end

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL sha256_message_hasher");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending_words == 0) begin
      $display("PASS sha256_message_hasher");
    end else begin
      $display("FAIL sha256_message_hasher");
    end
    $finish;
  end
endmodule
